@@ src/ternary_max_heap_defines.svh @@
// Assertion macros shared by the heap checker.
`ifndef TERNARY_MAX_HEAP_DEFINES_SVH
`define TERNARY_MAX_HEAP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TMH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TMH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/tmh_pkg.sv @@
// Types and constants of the ternary max-heap.
package tmh_pkg;

    localparam int DATA_W    = 32;
    localparam int CNT_OUT_W = 9;

    // Request codes
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Divide by three: floor(x / 3) = (x * DIV3_MUL) >> DIV3_SHIFT for x below 2^16
    localparam int          DIV_W      = 16;
    localparam logic [16:0] DIV3_MUL   = 17'd43691;
    localparam int          DIV3_SHIFT = 17;

    typedef struct packed {
        logic                     req_type;
        logic signed [DATA_W-1:0] push_value;
    } tmh_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] max_value;
        logic                     is_empty;
        logic [CNT_OUT_W-1:0]     entry_count;
        logic [1:0]               status;
    } tmh_rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic       accept;
        logic [1:0] stat;
        logic       push_load;
        logic       pop_dec;
        logic       up_par;
        logic       rd_par;
        logic       rd_last;
        logic       rd_child;
        logic [1:0] child_k;
        logic       wr_val;
        logic       wr_rd;
        logic       wr_best;
        logic       load_last;
        logic       best_clr;
        logic       finish;
    } tmh_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic req_pop;
        logic full;
        logic empty;
        logic pos_zero;
        logic child_ok;
        logic up_gt;
        logic down_gt;
    } tmh_sts_t;

endpackage

@@ src/tmh_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/tmh_ctrl.sv @@
// Sequencer of the heap: push sift-up and pop sift-down steps.
module tmh_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tmh_pkg::tmh_sts_t sts,
    output tmh_pkg::tmh_cmd_t cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_UP    = 3'd1;
    localparam logic [2:0] S_UPRD  = 3'd2;
    localparam logic [2:0] S_UPCMP = 3'd3;
    localparam logic [2:0] S_LRD   = 3'd4;
    localparam logic [2:0] S_LGET  = 3'd5;
    localparam logic [2:0] S_DN    = 3'd6;
    localparam logic [2:0] S_DEC   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [1:0] k_reg, k_next;

    assign busy = (state_reg != S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        cmd         = '0;
        cmd.stat    = tmh_pkg::ST_OK;
        cmd.child_k = k_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (!sts.req_pop)
                    begin
                        if (sts.full)
                        begin
                            cmd.stat   = tmh_pkg::ST_FULL;
                            cmd.finish = 1'b1;
                        end
                        else
                        begin
                            cmd.push_load = 1'b1;
                            state_next    = S_UP;
                        end
                    end
                    else
                    begin
                        if (sts.empty)
                        begin
                            cmd.stat   = tmh_pkg::ST_EMPTY;
                            cmd.finish = 1'b1;
                        end
                        else
                        begin
                            cmd.pop_dec = 1'b1;
                            state_next  = S_LRD;
                        end
                    end
                end
            end
            S_UP:
            begin
                if (sts.pos_zero)
                begin
                    cmd.wr_val = 1'b1;
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.up_par = 1'b1;
                    state_next = S_UPRD;
                end
            end
            S_UPRD:
            begin
                cmd.rd_par = 1'b1;
                state_next = S_UPCMP;
            end
            S_UPCMP:
            begin
                if (sts.up_gt)
                begin
                    cmd.wr_rd  = 1'b1;
                    state_next = S_UP;
                end
                else
                begin
                    cmd.wr_val = 1'b1;
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_LRD:
            begin
                cmd.rd_last = 1'b1;
                state_next  = S_LGET;
            end
            S_LGET:
            begin
                cmd.load_last = 1'b1;
                cmd.best_clr  = 1'b1;
                k_next        = 2'd1;
                if (sts.empty)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DN;
                end
            end
            S_DN:
            begin
                // Children are read one per cycle, compared as they arrive
                if (sts.child_ok)
                begin
                    cmd.rd_child = 1'b1;
                end
                if (sts.child_ok && (k_reg != 2'd3))
                begin
                    k_next = k_reg + 2'd1;
                end
                else
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (sts.down_gt)
                begin
                    cmd.wr_best  = 1'b1;
                    cmd.best_clr = 1'b1;
                    k_next       = 2'd1;
                    state_next   = S_DN;
                end
                else
                begin
                    cmd.wr_val = 1'b1;
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= 2'd1;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

endmodule

@@ src/tmh_dp.sv @@
// Datapath of the heap: store, hole position, carried value and compares.
module tmh_dp #(
    parameter int CAPACITY = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tmh_pkg::tmh_cmd_t cmd,
    input  tmh_pkg::tmh_req_t request,
    output tmh_pkg::tmh_sts_t sts,
    output tmh_pkg::tmh_rsp_t result,
    output logic              done
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;

    logic [CW-1:0]                     cnt_reg, cnt_next;
    logic [AW-1:0]                     pos_reg, pos_next;
    logic [AW-1:0]                     par_reg, par_next;
    logic signed [tmh_pkg::DATA_W-1:0] val_reg, val_next;
    logic signed [tmh_pkg::DATA_W-1:0] root_reg, root_next;
    logic [AW-1:0]                     best_reg, best_next;
    logic signed [tmh_pkg::DATA_W-1:0] bval_reg, bval_next;
    logic                              bvalid_reg, bvalid_next;
    logic                              pend_reg;
    logic [AW-1:0]                     pidx_reg, pidx_next;
    logic [1:0]                        stat_reg, stat_next;
    tmh_pkg::tmh_rsp_t                 rsp_reg, rsp_next;
    logic                              done_reg;

    logic [IW-1:0]                     cidx;
    logic [tmh_pkg::DIV_W-1:0]         pm1;
    logic [32:0]                       prod;
    logic                              take;
    logic signed [tmh_pkg::DATA_W-1:0] eff_bval;
    logic [AW-1:0]                     eff_best;
    logic                              eff_bvalid;

    logic                              ram_we, ram_re;
    logic [AW-1:0]                     ram_raddr;
    logic [tmh_pkg::DATA_W-1:0]        ram_wdata, ram_rdata;

    tmh_ram #(
        .WIDTH (tmh_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Child address 3*pos + k and parent (pos - 1) / 3
    assign cidx = (IW'(pos_reg) << 1) + IW'(pos_reg) + IW'(cmd.child_k);
    assign pm1  = tmh_pkg::DIV_W'(pos_reg) - tmh_pkg::DIV_W'(1);
    assign prod = 33'(pm1) * 33'(tmh_pkg::DIV3_MUL);

    // Running best child, folding in the read that lands this cycle
    assign take       = pend_reg && (!bvalid_reg || ($signed(ram_rdata) > bval_reg));
    assign eff_bval   = take ? $signed(ram_rdata) : bval_reg;
    assign eff_best   = take ? pidx_reg : best_reg;
    assign eff_bvalid = bvalid_reg || pend_reg;

    // Status to the controller
    always_comb
    begin
        sts.req_pop  = (request.req_type == tmh_pkg::REQ_POP);
        sts.full     = (cnt_reg == CW'(CAPACITY));
        sts.empty    = (cnt_reg == '0);
        sts.pos_zero = (pos_reg == '0);
        sts.child_ok = (cidx < IW'(cnt_reg));
        sts.up_gt    = (val_reg > $signed(ram_rdata));
        sts.down_gt  = eff_bvalid && (eff_bval > val_reg);
    end

    // Store ports
    always_comb
    begin
        ram_we = cmd.wr_val || cmd.wr_rd || cmd.wr_best;
        ram_re = cmd.rd_par || cmd.rd_last || cmd.rd_child;
        if (cmd.wr_rd)
        begin
            ram_wdata = ram_rdata;
        end
        else if (cmd.wr_best)
        begin
            ram_wdata = eff_bval;
        end
        else
        begin
            ram_wdata = val_reg;
        end
        if (cmd.rd_par)
        begin
            ram_raddr = par_reg;
        end
        else if (cmd.rd_last)
        begin
            ram_raddr = AW'(cnt_reg);
        end
        else
        begin
            ram_raddr = cidx[AW-1:0];
        end
    end

    // Next values
    always_comb
    begin
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        par_next    = par_reg;
        val_next    = val_reg;
        root_next   = root_reg;
        best_next   = eff_best;
        bval_next   = eff_bval;
        bvalid_next = eff_bvalid;
        pidx_next   = pidx_reg;
        stat_next   = stat_reg;
        rsp_next    = rsp_reg;

        if (cmd.push_load)
        begin
            cnt_next = cnt_reg + CW'(1);
            pos_next = AW'(cnt_reg);
            val_next = request.push_value;
        end
        if (cmd.pop_dec)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
        if (cmd.up_par)
        begin
            par_next = AW'(prod >> tmh_pkg::DIV3_SHIFT);
        end
        if (cmd.wr_rd)
        begin
            pos_next = par_reg;
        end
        if (cmd.wr_best)
        begin
            pos_next = eff_best;
        end
        if (cmd.load_last)
        begin
            pos_next = '0;
            val_next = $signed(ram_rdata);
        end
        if (cmd.best_clr)
        begin
            bvalid_next = 1'b0;
        end
        if (cmd.rd_child)
        begin
            pidx_next = cidx[AW-1:0];
        end
        // Root copy follows every write to the top entry
        if (ram_we && (pos_reg == '0))
        begin
            root_next = $signed(ram_wdata);
        end
        if (cmd.accept)
        begin
            stat_next = cmd.stat;
        end
        if (cmd.finish)
        begin
            rsp_next.max_value   = (cnt_next != '0) ? root_next : '0;
            rsp_next.is_empty    = (cnt_next == '0);
            rsp_next.entry_count = tmh_pkg::CNT_OUT_W'(cnt_next);
            rsp_next.status      = stat_next;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            bvalid_reg <= 1'b0;
            pend_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            bvalid_reg <= bvalid_next;
            pend_reg   <= cmd.rd_child;
            done_reg   <= cmd.finish;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        par_reg  <= par_next;
        val_reg  <= val_next;
        root_reg <= root_next;
        best_reg <= best_next;
        bval_reg <= bval_next;
        pidx_reg <= pidx_next;
        stat_reg <= stat_next;
        rsp_reg  <= rsp_next;
    end

    assign result = rsp_reg;
    assign done   = done_reg;

endmodule

@@ src/ternary_max_heap.sv @@
// Top level of the ternary max-heap priority queue.
//
//  channel   handshake              payload
//  request   start && !busy         request (req_type, push_value)
//  result    done, one cycle        result (max_value, is_empty, entry_count, status)
//
// A push places the new value at the end, then per level climbed computes the parent,
// reads it and compares. A pop carries the last entry down from the root, and per level
// it visits does up to three child reads from the single read port of the store, then
// a decide/write step. done pulses the cycle after the last step, with busy already low.
// Reset empties the heap; the store itself is not cleared.
module ternary_max_heap #(
    parameter int CAPACITY = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tmh_pkg::tmh_req_t request,
    output logic              done,
    output tmh_pkg::tmh_rsp_t result
);

    tmh_pkg::tmh_cmd_t cmd;
    tmh_pkg::tmh_sts_t sts;

    tmh_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    tmh_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .sts     (sts),
        .result  (result),
        .done    (done)
    );

endmodule

@@ src/tmh_checker.sv @@
// Port-level checks of the heap, bound to the top level.
`include "ternary_max_heap_defines.svh"

module tmh_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input tmh_pkg::tmh_rsp_t result
);

    `TMH_ASSERT_NEXT(a_accept_leads, start && !busy, busy || done, "accepted transaction lost")
    `TMH_ASSERT_NOW(a_done_idle, done, !busy, "result while still busy")
    `TMH_ASSERT_NOW(a_empty_zero, done && result.is_empty, (result.max_value == 0) && (result.entry_count == 0), "empty heap reports data")
    `TMH_ASSERT_NOW(a_pop_empty, done && (result.status == tmh_pkg::ST_EMPTY), result.is_empty, "ignored pop on a non-empty heap")

endmodule

bind ternary_max_heap tmh_checker u_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .result  (result)
);
